/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during rst_n low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/wasa_pkg.sv */
// ----------------------------------------------------------------------------
// wasa_pkg
// widths, constants and shared types of the windowed activity score alert
// ----------------------------------------------------------------------------
package wasa_pkg;

  localparam int WINDOW     = 16;

  localparam int AREA_W     = 24;
  localparam int PIX_W      = 24;
  localparam int SENS_W     = 10;
  localparam int SENS_FRAC  = 8;
  localparam int SCORE_W    = 7;
  localparam int RAW_W      = 12;

  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = AREA_W + POS_W;
  localparam int NUM_W      = SUM_W + 11;
  localparam int MIL_W      = SUM_W + 10;
  localparam int DEN_W      = CNT_W + PIX_W;
  localparam int DSH_W      = DEN_W + RAW_W - 1;
  localparam int WIDE_W     = NUM_W + 2;
  localparam int DIV_CNT_W  = $clog2(RAW_W);
  localparam int THR_W      = 18;
  localparam int THR_CMP_W  = RAW_W + SENS_FRAC;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [10:0]        NUM_SCALE  = 11'd2000;
  localparam logic [9:0]         MEAN_SCALE = 10'd1000;
  localparam logic [RAW_W-1:0]   RAW_MAX    = '1;
  localparam logic [THR_W-1:0]   THR_BASE   = 18'd25600;
  localparam logic [7:0]         THR_SLOPE  = 8'd200;
  localparam logic [SCORE_W-1:0] SCORE_FULL = 7'd100;
  localparam logic [PIX_W-1:0]   PIX_RESET  = 24'd1;
  localparam logic [SENS_W-1:0]  SENS_RESET = 10'd128;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IMAGE_PIXELS = 2'd0;
  localparam cfg_idx_t REG_SENSITIVITY  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic update;
    logic mul;
    logic prep;
    logic step;
    logic finish;
  } ctrl_t;

endpackage

/* rtl/core/wasa_in_if.sv */
// ----------------------------------------------------------------------------
// wasa_in_if
// input channel: one frame's summed motion area per transaction
// ----------------------------------------------------------------------------
interface wasa_in_if;
  import wasa_pkg::*;

  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] area_total;

  modport source (output valid, output area_total, input ready);
  modport sink   (input valid, input area_total, output ready);
endinterface

/* rtl/core/wasa_out_if.sv */
// ----------------------------------------------------------------------------
// wasa_out_if
// result channel: stillness score and warning flag per transaction
// ----------------------------------------------------------------------------
interface wasa_out_if;
  import wasa_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               warning;

  modport source (output valid, output score, output warning, input ready);
  modport sink   (input valid, input score, input warning, output ready);
endinterface

/* rtl/core/wasa_window.sv */
// ----------------------------------------------------------------------------
// wasa_window
// ring memory of recent frame areas with fill count and running sum
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wasa_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wasa_pkg::ctrl_t              ctrl,
  input  logic [wasa_pkg::AREA_W-1:0]  area_i,
  output logic [wasa_pkg::SUM_W-1:0]   sum_o,
  output logic [wasa_pkg::CNT_W-1:0]   fill_o
);
  import wasa_pkg::*;

  logic [AREA_W-1:0] mem [WINDOW];
  logic [AREA_W-1:0] rd_r;
  logic [AREA_W-1:0] area_r;

  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r,  sum_nxt;
  logic              full;

  // oldest entry is fetched at accept, overwritten in the cycle after
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rd_r   <= mem[pos_r];
      area_r <= area_i;
    end
    if (ctrl.update) begin
      mem[pos_r] <= area_r;
    end
  end

  assign full = (fill_r == CNT_W'(WINDOW));

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (ctrl.update) begin
      pos_nxt = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      if (full) begin
        sum_nxt = sum_r - SUM_W'(rd_r) + SUM_W'(area_r);
      end else begin
        fill_nxt = fill_r + 1'b1;
        sum_nxt  = sum_r + SUM_W'(area_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign sum_o  = sum_r;
  assign fill_o = fill_r;

  `ASSERT_ALWAYS(a_fill_max, fill_r <= CNT_W'(WINDOW), "fill count beyond window depth")
  `ASSERT_NEXT(a_update_after_read, ctrl.start, ctrl.update, "update not one cycle after read")
  `ASSERT_IMPLIES(a_pos_tracks_fill, !full, pos_r == POS_W'(fill_r),
                  "write position out of step with fill count")

endmodule

/* rtl/core/wasa_scorer.sv */
// ----------------------------------------------------------------------------
// wasa_scorer
// raw activity score by serial restoring division, warning and stillness score
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wasa_scorer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wasa_pkg::ctrl_t               ctrl,
  input  logic [wasa_pkg::SUM_W-1:0]    sum_i,
  input  logic [wasa_pkg::CNT_W-1:0]    fill_i,
  input  logic [wasa_pkg::PIX_W-1:0]    pix_i,
  input  logic [wasa_pkg::SENS_W-1:0]   sens_i,
  output logic                          div_last_o,
  output logic [wasa_pkg::SCORE_W-1:0]  score_o,
  output logic                          warning_o
);
  import wasa_pkg::*;

  logic [NUM_W-1:0]     num_r;
  logic [MIL_W-1:0]     mil_r;
  logic [DEN_W-1:0]     den_r;
  logic                 below_r;
  logic                 sat_r;
  logic [NUM_W-1:0]     rem_r;
  logic [DSH_W-1:0]     dsh_r;
  logic [RAW_W-1:0]     q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [RAW_W-1:0]     prev_raw_r;

  logic                 ge;
  logic [RAW_W-1:0]     raw;
  logic [THR_W-1:0]     thr;

  // products of the mean test, of the quotient numerator and of the divisor
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      num_r <= NUM_W'(sum_i) * NUM_W'(NUM_SCALE);
      mil_r <= MIL_W'(sum_i) * MIL_W'(MEAN_SCALE);
      den_r <= DEN_W'(fill_i) * DEN_W'(pix_i);
    end
  end

  assign ge = (WIDE_W'(rem_r) >= WIDE_W'(dsh_r));

  always_ff @(posedge clk) begin
    if (ctrl.prep) begin
      below_r   <= (WIDE_W'(mil_r) < WIDE_W'(den_r));
      // quotient of 2^RAW_W or more, zero divisor included
      sat_r     <= (WIDE_W'(num_r) >= (WIDE_W'(den_r) << RAW_W));
      rem_r     <= num_r;
      dsh_r     <= DSH_W'(den_r) << (RAW_W - 1);
      q_r       <= '0;
      div_cnt_r <= '0;
    end else if (ctrl.step) begin
      if (ge) begin
        rem_r <= rem_r - NUM_W'(dsh_r);
      end
      dsh_r     <= dsh_r >> 1;
      q_r       <= {q_r[RAW_W-2:0], ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  assign div_last_o = ctrl.step && (div_cnt_r == DIV_CNT_W'(RAW_W - 1));

  always_comb begin
    if (below_r) begin
      raw = '0;
    end else if (sat_r) begin
      raw = RAW_MAX;
    end else begin
      raw = q_r;
    end
  end

  // threshold in units of 1/256
  assign thr = THR_BASE + THR_W'(THR_SLOPE) * THR_W'(sens_i);

  assign warning_o = ({prev_raw_r, {SENS_FRAC{1'b0}}} < THR_CMP_W'(thr)) &&
                     ({raw, {SENS_FRAC{1'b0}}} > THR_CMP_W'(thr));

  assign score_o = (raw > RAW_W'(SCORE_FULL)) ? '0 :
                   SCORE_W'(RAW_W'(SCORE_FULL) - raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= '0;
    end else if (ctrl.finish) begin
      prev_raw_r <= raw;
    end
  end

  `ASSERT_IMPLIES(a_div_bounded, ctrl.step, div_cnt_r < DIV_CNT_W'(RAW_W),
                  "divider stepped past its last quotient bit")

endmodule

/* rtl/core/windowed_activity_score_alert_top.sv */
// ----------------------------------------------------------------------------
// windowed_activity_score_alert_top
// each transaction passes the update, multiply, prep, 12-step divide and output steps;
// input is accepted only in idle, so a new one waits until the last is through
// the input side stays open while a result waits in the output register
// sync active-low reset empties the window, clears sum and last raw score,
// sets image_pixels to 1 and sensitivity to 0.5; no memory clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_activity_score_alert_top (
  input  logic                             clk,
  input  logic                             rst_n,
  wasa_in_if.sink                          in_if,
  wasa_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  wasa_pkg::cfg_idx_t               cfg_idx,
  input  logic [wasa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wasa_pkg::*;

  state_t             state_r, state_nxt;
  ctrl_t              ctrl;
  logic               in_ready;
  logic               out_free;
  logic               div_last;

  logic [PIX_W-1:0]   pix_r;
  logic [SENS_W-1:0]  sens_r;

  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   fill;
  logic [SCORE_W-1:0] score;
  logic               warning;

  logic               out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_warning_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r  <= PIX_RESET;
      sens_r <= SENS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_PIXELS: pix_r  <= cfg_wdata[PIX_W-1:0];
        REG_SENSITIVITY:  sens_r <= cfg_wdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_if.valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.start = in_if.valid;
      end
      ST_UPDATE: ctrl.update = 1'b1;
      ST_MUL:    ctrl.mul    = 1'b1;
      ST_PREP:   ctrl.prep   = 1'b1;
      ST_DIV:    ctrl.step   = 1'b1;
      ST_OUT:    ctrl.finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  wasa_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .area_i (in_if.area_total),
    .sum_o  (sum),
    .fill_o (fill)
  );

  wasa_scorer u_scorer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sum_i      (sum),
    .fill_i     (fill),
    .pix_i      (pix_r),
    .sens_i     (sens_r),
    .div_last_o (div_last),
    .score_o    (score),
    .warning_o  (warning)
  );

  // output register decouples result hand-off from the next transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_score_r   <= score;
      out_warning_r <= warning;
    end
  end

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.score   = out_score_r;
  assign out_if.warning = out_warning_r;

  `ASSERT_NEXT(a_result_follows, ctrl.finish, out_valid_r, "finished item left no result")

endmodule
